### design/cvid_pkg.sv
// Shared constants, codes and controller/datapath interface types for the interval decomposer.
package cvid_pkg;

    // Store geometry.
    localparam int MAX_SEGMENTS = 256;
    localparam int COUNT_BITS   = 8;
    localparam int IDX_W        = $clog2(MAX_SEGMENTS);
    localparam int POS_W        = IDX_W + 1;

    // Width of the segment index and position fields on the ports.
    localparam int FIELD_W   = 8;
    localparam int SEG_EXT_W = (IDX_W > FIELD_W) ? IDX_W : FIELD_W;

    // Scan phases.
    localparam logic [1:0] PHASE_DEL  = 2'd0;
    localparam logic [1:0] PHASE_AMP  = 2'd1;
    localparam logic [1:0] PHASE_DONE = 2'd2;

    // Input command codes.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_FETCH = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;          // apply the accepted load transaction
        logic adv_phase;     // move to the next phase, scan position back to zero
        logic adv_pos;       // skip a zero entry
        logic cur_from_pos;  // run cursor starts at the scan position
        logic cur_inc;       // run cursor steps forward
        logic rd_next;       // read address is cursor + 1 instead of scan position
        logic dec_wr;        // write back the decremented count at the cursor
        logic res_event;     // capture an interval event result
        logic res_end_prev;  // the run ended one entry before the cursor
        logic res_done;      // capture a done result
        logic out_load;      // move the captured result into the output register
    } cvid_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic active;         // phase is deletion or amplification
        logic pos_lt_total;   // scan position is inside the loaded segments
        logic next_in_range;  // cursor + 1 is inside the loaded segments
        logic data_nz;        // count read back is nonzero
        logic at_head;        // cursor sits at the scan position
        logic out_free;       // output register can take a result this cycle
    } cvid_status_t;

endpackage

### design/cvid_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module cvid_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read; contents are undefined until written.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/cvid_ctrl.sv
// Controller state machine that sequences loads, the scan and result hand-off.
module cvid_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic                  command,
    input  cvid_pkg::cvid_status_t status,
    output cvid_pkg::cvid_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EVAL,
        ST_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == ST_IDLE);

    // Next state and datapath commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (command == cvid_pkg::CMD_LOAD) begin
                        cmd.load = 1'b1;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (!status.active) begin
                    cmd.res_done = 1'b1;
                    state_next   = ST_OUT;
                end else if (!status.pos_lt_total) begin
                    cmd.adv_phase = 1'b1;
                end else begin
                    cmd.cur_from_pos = 1'b1;
                    state_next       = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (!status.data_nz) begin
                    if (status.at_head) begin
                        cmd.adv_pos = 1'b1;
                        state_next  = ST_SCAN;
                    end else begin
                        cmd.res_event    = 1'b1;
                        cmd.res_end_prev = 1'b1;
                        state_next       = ST_OUT;
                    end
                end else begin
                    cmd.dec_wr = 1'b1;
                    if (status.next_in_range) begin
                        cmd.rd_next = 1'b1;
                        cmd.cur_inc = 1'b1;
                    end else begin
                        cmd.res_event = 1'b1;
                        state_next    = ST_OUT;
                    end
                end
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### design/cvid_datapath.sv
// Datapath: count stores, scan position, phase, run cursor and the result register.
module cvid_datapath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cvid_pkg::cvid_cmd_t    cmd,
    output cvid_pkg::cvid_status_t status,
    input  logic [7:0]            seg_index,
    input  logic [7:0]            del_count,
    input  logic [7:0]            amp_count,
    input  logic                  last_seg,
    input  logic                  m_tready,
    output logic                  m_valid,
    output logic                  m_kind,
    output logic [7:0]            m_start,
    output logic [7:0]            m_end,
    output logic                  m_done
);

    localparam int IDX_W     = cvid_pkg::IDX_W;
    localparam int POS_W     = cvid_pkg::POS_W;
    localparam int CNT_W     = cvid_pkg::COUNT_BITS;
    localparam int SEG_EXT_W = cvid_pkg::SEG_EXT_W;

    // Control state.
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [1:0]       phase_reg, phase_next;
    logic [POS_W-1:0] total_reg, total_next;
    logic             m_valid_reg, m_valid_next;

    // Payload state.
    logic [POS_W-1:0] cur_reg;
    logic             res_kind_reg, res_done_reg;
    logic [7:0]       res_start_reg, res_end_reg;
    logic             m_kind_reg, m_done_reg;
    logic [7:0]       m_start_reg, m_end_reg;

    // Load decode.
    logic [SEG_EXT_W-1:0] seg_ext;
    logic                 seg_in_range;
    logic [31:0]          total_raw;
    logic [POS_W-1:0]     total_sat;

    // Store ports.
    logic             del_we, amp_we;
    logic [IDX_W-1:0] waddr, raddr;
    logic [CNT_W-1:0] del_wdata, amp_wdata, del_rdata, amp_rdata, rd_sel, rd_dec;
    logic [POS_W-1:0] cur_plus, cur_minus, rd_pos;

    assign seg_ext      = SEG_EXT_W'(seg_index);
    assign seg_in_range = 32'(seg_ext) < 32'(cvid_pkg::MAX_SEGMENTS);
    assign total_raw    = 32'(seg_ext) + 32'd1;
    assign total_sat    = (total_raw > 32'(cvid_pkg::MAX_SEGMENTS))
                        ? POS_W'(cvid_pkg::MAX_SEGMENTS) : POS_W'(total_raw);

    assign cur_plus  = cur_reg + POS_W'(1);
    assign cur_minus = cur_reg - POS_W'(1);
    assign rd_pos    = cmd.rd_next ? cur_plus : pos_reg;
    assign raddr     = rd_pos[IDX_W-1:0];

    assign rd_sel = phase_reg[0] ? amp_rdata : del_rdata;
    assign rd_dec = rd_sel - CNT_W'(1);

    // Write port: loads fill both stores, a run decrements the active store.
    always_comb begin
        if (cmd.load) begin
            waddr     = seg_ext[IDX_W-1:0];
            del_we    = seg_in_range;
            amp_we    = seg_in_range;
            del_wdata = CNT_W'(del_count);
            amp_wdata = CNT_W'(amp_count);
        end else begin
            waddr     = cur_reg[IDX_W-1:0];
            del_we    = cmd.dec_wr && (phase_reg == cvid_pkg::PHASE_DEL);
            amp_we    = cmd.dec_wr && (phase_reg == cvid_pkg::PHASE_AMP);
            del_wdata = rd_dec;
            amp_wdata = rd_dec;
        end
    end

    cvid_ram #(
        .WIDTH (CNT_W),
        .DEPTH (cvid_pkg::MAX_SEGMENTS)
    ) u_del_store (
        .aclk  (aclk),
        .we    (del_we),
        .waddr (waddr),
        .wdata (del_wdata),
        .raddr (raddr),
        .rdata (del_rdata)
    );

    cvid_ram #(
        .WIDTH (CNT_W),
        .DEPTH (cvid_pkg::MAX_SEGMENTS)
    ) u_amp_store (
        .aclk  (aclk),
        .we    (amp_we),
        .waddr (waddr),
        .wdata (amp_wdata),
        .raddr (raddr),
        .rdata (amp_rdata)
    );

    // Status back to the controller.
    assign status.active        = !phase_reg[1];
    assign status.pos_lt_total  = pos_reg < total_reg;
    assign status.next_in_range = cur_plus < total_reg;
    assign status.data_nz       = rd_sel != '0;
    assign status.at_head       = cur_reg == pos_reg;
    assign status.out_free      = !m_valid_reg || m_tready;

    // Scan position, phase and segment total.
    always_comb begin
        pos_next   = pos_reg;
        phase_next = phase_reg;
        total_next = total_reg;
        if (cmd.load) begin
            if (seg_ext == '0) begin
                pos_next   = '0;
                phase_next = cvid_pkg::PHASE_DEL;
                total_next = '0;
            end
            if (last_seg) begin
                total_next = total_sat;
            end
        end else if (cmd.adv_phase) begin
            phase_next = phase_reg + 2'd1;
            pos_next   = '0;
        end else if (cmd.adv_pos) begin
            pos_next = pos_reg + POS_W'(1);
        end
    end

    // Output valid: set when a result is handed over, cleared when taken.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            phase_reg   <= cvid_pkg::PHASE_DEL;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            phase_reg   <= phase_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Run cursor, captured result and output payload.
    always_ff @(posedge aclk) begin
        if (cmd.cur_from_pos) begin
            cur_reg <= pos_reg;
        end else if (cmd.cur_inc) begin
            cur_reg <= cur_plus;
        end
        if (cmd.res_event) begin
            res_kind_reg  <= phase_reg[0];
            res_start_reg <= 8'(pos_reg);
            res_end_reg   <= cmd.res_end_prev ? 8'(cur_minus) : 8'(cur_reg);
            res_done_reg  <= 1'b0;
        end else if (cmd.res_done) begin
            res_kind_reg  <= 1'b0;
            res_start_reg <= '0;
            res_end_reg   <= '0;
            res_done_reg  <= 1'b1;
        end
        if (cmd.out_load) begin
            m_kind_reg  <= res_kind_reg;
            m_start_reg <= res_start_reg;
            m_end_reg   <= res_end_reg;
            m_done_reg  <= res_done_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_kind  = m_kind_reg;
    assign m_start = m_start_reg;
    assign m_end   = m_end_reg;
    assign m_done  = m_done_reg;

endmodule

### design/count_vector_interval_decomposer_top.sv
// Top level of the count vector interval decomposer: stream ports, controller and datapath.
//
// Input stream (s_): each transaction is a load (s_tuser = 0) or a fetch (s_tuser = 1).
// A load writes one segment's deletion and amplification counts; loading segment 0
// restarts the scan, and s_tlast marks the final segment, which fixes the segment count.
// A load gives no result.
// Output stream (m_): every fetch gives exactly one result transaction, the next unit
// interval (kind, start, end), or a done flag once both count vectors are exhausted.
// A fetch walks the scan through the single read port of each count store, one entry at
// a time, skipping zero entries and moving to the next phase at the end of the segments.
// Results leave through an output register, so a new transaction is accepted while the
// previous result still waits; a fetch whose result is ready holds in the last step
// until the receiver takes the waiting one.
// Reset (aresetn low, synchronous) clears the scan position, phase, segment count and
// output valid; the count stores are undefined until loaded and need no clearing.
module count_vector_interval_decomposer_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // segment_index, deletion_count, amplification_count
    input  logic [0:0]  s_tuser,  // command
    input  logic        s_tlast,  // last_segment
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,  // event_start, event_end
    output logic [1:0]  m_tuser   // event_kind, done_res
);

    cvid_pkg::cvid_cmd_t    cmd;
    cvid_pkg::cvid_status_t status;

    logic       event_kind;
    logic [7:0] event_start;
    logic [7:0] event_end;
    logic       done_res;

    cvid_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .command  (s_tuser[0]),
        .status   (status),
        .cmd      (cmd)
    );

    cvid_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .seg_index (s_tdata[7:0]),
        .del_count (s_tdata[15:8]),
        .amp_count (s_tdata[23:16]),
        .last_seg  (s_tlast),
        .m_tready  (m_tready),
        .m_valid   (m_tvalid),
        .m_kind    (event_kind),
        .m_start   (event_start),
        .m_end     (event_end),
        .m_done    (done_res)
    );

    // Pack the result transaction.
    assign m_tdata = {event_end, event_start};
    assign m_tuser = {done_res, event_kind};

endmodule
